/* hdl/ygck_pkg.sv */
// Shared types, constants and helpers for the YUV gamut check and key block.
`default_nettype none

package ygck_pkg;

    localparam int CompW  = 16;
    localparam int DiffW  = 18;
    localparam int ProdW  = 36;
    localparam int SumW   = 38;
    localparam int ScaleSh = 17;

    localparam logic [4:0] DepthMin = 5'd8;
    localparam logic [4:0] DepthMax = 5'd16;
    localparam logic [4:0] DepthRst = 5'd8;

    // coefficients at 16 fractional bits
    localparam logic signed [DiffW-1:0] Bt709Gu = 18'sd12275;
    localparam logic signed [DiffW-1:0] Bt709Gv = 18'sd30677;
    localparam logic signed [DiffW-1:0] Bt709Kr = 18'sd103206;
    localparam logic signed [DiffW-1:0] Bt709Kb = 18'sd121609;
    localparam logic signed [DiffW-1:0] Bt601Gu = 18'sd22554;
    localparam logic signed [DiffW-1:0] Bt601Gv = 18'sd46802;
    localparam logic signed [DiffW-1:0] Bt601Kr = 18'sd91881;
    localparam logic signed [DiffW-1:0] Bt601Kb = 18'sd116130;

    typedef enum logic [2:0] {
        REG_MATRIX = 3'd0,
        REG_DEPTH  = 3'd1,
        REG_KEY_Y  = 3'd2,
        REG_KEY_CB = 3'd3,
        REG_KEY_CR = 3'd4,
        REG_KEY_A  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [CompW-1:0] alpha;
        logic [CompW-1:0] cr;
        logic [CompW-1:0] cb;
        logic [CompW-1:0] luma;
    } pix_t;

    typedef struct packed {
        pix_t                    pix;
        logic [CompW-1:0]        fs;
        logic signed [DiffW-1:0] du;
        logic signed [DiffW-1:0] dv;
        logic                    over;
    } prep_t;

    typedef struct packed {
        pix_t                    pix;
        logic [CompW-1:0]        fs;
        logic                    over;
        logic signed [ProdW-1:0] gu_du;
        logic signed [ProdW-1:0] gv_dv;
        logic signed [ProdW-1:0] kr_dv;
        logic signed [ProdW-1:0] kb_du;
    } prod_t;

    function automatic logic [CompW-1:0] full_scale(input logic [4:0] depth);
        logic [4:0]       dc;
        logic [CompW:0]   one;
        dc = depth;
        if (dc < DepthMin)
        begin
            dc = DepthMin;
        end
        if (dc > DepthMax)
        begin
            dc = DepthMax;
        end
        one = 17'd1 << dc;
        return CompW'(one - 17'd1);
    endfunction

endpackage

`default_nettype wire

/* hdl/ygck_prep.sv */
// Stage one: full scale from depth, centered chroma and over-range flag.
`default_nettype none

module ygck_prep
    import ygck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [4:0] depth,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire pix_t       in_pix,
    output logic            out_valid,
    input  wire logic       out_ready,
    output prep_t           out_word
);

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;
    logic [CompW-1:0] fs;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    always_comb
    begin
        fs = full_scale(depth);
        data_next.pix  = in_pix;
        data_next.fs   = fs;
        data_next.du   = signed'({1'b0, in_pix.cb, 1'b0}) - signed'({2'b0, fs});
        data_next.dv   = signed'({1'b0, in_pix.cr, 1'b0}) - signed'({2'b0, fs});
        data_next.over = (in_pix.cb > fs) || (in_pix.cr > fs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ygck_mult.sv */
// Stage two: the four coefficient products of the selected matrix.
`default_nettype none

module ygck_mult
    import ygck_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  matrix_sel,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire prep_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output prod_t      out_word
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;
    logic signed [DiffW-1:0] gu;
    logic signed [DiffW-1:0] gv;
    logic signed [DiffW-1:0] kr;
    logic signed [DiffW-1:0] kb;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = data_reg;

    always_comb
    begin
        gu = matrix_sel ? Bt709Gu : Bt601Gu;
        gv = matrix_sel ? Bt709Gv : Bt601Gv;
        kr = matrix_sel ? Bt709Kr : Bt601Kr;
        kb = matrix_sel ? Bt709Kb : Bt601Kb;
        data_next.pix   = in_data.pix;
        data_next.fs    = in_data.fs;
        data_next.over  = in_data.over;
        data_next.gu_du = gu * in_data.du;
        data_next.gv_dv = gv * in_data.dv;
        data_next.kr_dv = kr * in_data.dv;
        data_next.kb_du = kb * in_data.du;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ygck_cmp.sv */
// Stage three: gamut bound compares, key replacement and output register.
`default_nettype none

module ygck_cmp
    import ygck_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire pix_t  key,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire prod_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pix_t       out_pix,
    output logic       out_inside
);

    logic valid_reg;
    pix_t pix_reg;
    pix_t pix_next;
    logic inside_reg;
    logic inside_next;

    logic signed [SumW-1:0]  gsum;
    logic signed [SumW-1:0]  y2;
    logic signed [SumW-1:0]  fsq;
    logic signed [SumW-1:0]  head;
    logic signed [CompW:0]   diff;
    logic signed [SumW-1:0]  kr_dv;
    logic signed [SumW-1:0]  kb_du;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_pix    = pix_reg;
    assign out_inside = inside_reg;

    always_comb
    begin
        gsum  = SumW'(in_data.gu_du) + SumW'(in_data.gv_dv);
        kr_dv = SumW'(in_data.kr_dv);
        kb_du = SumW'(in_data.kb_du);
        y2    = signed'({5'b0, in_data.pix.luma, {ScaleSh{1'b0}}});
        fsq   = signed'({5'b0, in_data.fs, {ScaleSh{1'b0}}});
        diff  = signed'({1'b0, in_data.fs}) - signed'({1'b0, in_data.pix.luma});
        head  = SumW'(signed'({diff, {ScaleSh{1'b0}}}));
        inside_next = !in_data.over
                   && (fsq + gsum >= y2)
                   && (gsum <= y2)
                   && (kr_dv >= -y2)
                   && (kr_dv <= head)
                   && (kb_du >= -y2)
                   && (kb_du <= head);
        pix_next = inside_next ? in_data.pix : key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg    <= pix_next;
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/yuv_gamut_check_key.sv */
// Top level of the YUVA gamut check with key replacement.
//
//  channel  direction  handshake         payload
//  s_axis   in         s_tvalid/tready   s_tdata: luma, cb, cr, alpha
//  m_axis   out        m_tvalid/tready   m_tdata: out pixel; m_tuser: inside_res
//  cfg      in         cfg_valid/ready   cfg_index, cfg_data
//
// One item per cycle unless m_tready stalls the output; items pass through the prep,
// multiply and compare registers. The last stage is the output register.
// While m_tready is low, earlier stages keep taking items until each holds one;
// s_tready drops in the same cycle once all three stages are full.
// Reset clears the valid bits and sets the registers to BT.601, depth 8, key 0.
`default_nettype none

module yuv_gamut_check_key
    import ygck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // luma, cb, cr, alpha
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_luma, out_cb, out_cr, out_alpha
    output logic             m_tuser,   // inside_res
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic       matrix_reg;
    logic [4:0] depth_reg;
    pix_t       key_reg;

    logic  p_valid;
    logic  p_ready;
    prep_t p_data;
    logic  x_valid;
    logic  x_ready;
    prod_t x_data;
    pix_t  o_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg <= 1'b0;
            depth_reg  <= DepthRst;
            key_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MATRIX: matrix_reg    <= cfg_data[0];
                REG_DEPTH:  depth_reg     <= cfg_data[4:0];
                REG_KEY_Y:  key_reg.luma  <= cfg_data;
                REG_KEY_CB: key_reg.cb    <= cfg_data;
                REG_KEY_CR: key_reg.cr    <= cfg_data;
                REG_KEY_A:  key_reg.alpha <= cfg_data;
                default: ;
            endcase
        end
    end

    ygck_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .depth     (depth_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pix_t'(s_tdata)),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_word  (p_data)
    );

    ygck_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .matrix_sel (matrix_reg),
        .in_valid   (p_valid),
        .in_ready   (p_ready),
        .in_data    (p_data),
        .out_valid  (x_valid),
        .out_ready  (x_ready),
        .out_word   (x_data)
    );

    ygck_cmp u_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_reg),
        .in_valid   (x_valid),
        .in_ready   (x_ready),
        .in_data    (x_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (o_pix),
        .out_inside (m_tuser)
    );

    assign m_tdata = o_pix;

endmodule

`default_nettype wire

/* hdl/ygck_checker.sv */
// Port-level checker for the gamut check block, bound to the top level.
`default_nettype none

module ygck_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb
    begin
        occ_next = occ_reg;
        if (s_fire && !m_fire)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (m_fire && !s_fire)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ_reg != 2'd0)
        else $error("output item without an accepted input item");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 2'd0 |-> s_tready)
        else $error("empty pipeline refuses input");

    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 2'd3 && !m_tready |-> !s_tready)
        else $error("input taken with pipeline full and output stalled");

endmodule

bind yuv_gamut_check_key ygck_checker u_ygck_checker (.*);

`default_nettype wire
